[hdl/lts_pkg.sv]
// Shared types, codes and defaults of the lottery task selector.
`default_nettype none

package lts_pkg;

    localparam int MAX_TASKS_DEF   = 16;
    localparam int TICKET_BITS_DEF = 16;
    localparam int RND_BITS        = 32;

    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_GRANTED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SCHED = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] ticket_count;
        logic [31:0] random_value;
        logic        current_done;
    } req_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
    } rsp_word_t;

    typedef struct packed {
        logic capture;
        logic do_load;
        logic ret_apply;
        logic div_start;
        logic div_step;
        logic scan_start;
        logic scan_step;
        logic res_grant;
        logic res_empty;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic in_kind;
        logic none_left;
        logic div_last;
        logic scan_hit;
        logic scan_end;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

[hdl/lts_ctrl.sv]
// Sequencer of the lottery task selector: load, retire, modulo and scan steps.
`default_nettype none

module lts_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire lts_pkg::stat_t stat,
    output lts_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_LOAD      = 3'd1;
    localparam logic [2:0] S_RET_RD    = 3'd2;
    localparam logic [2:0] S_RET_APPLY = 3'd3;
    localparam logic [2:0] S_CHECK     = 3'd4;
    localparam logic [2:0] S_DIV       = 3'd5;
    localparam logic [2:0] S_SCAN      = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    if (stat.in_kind == lts_pkg::KIND_SCHED)
                        state_next = S_RET_RD;
                    else
                        state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.do_load = 1'b1;
                state_next  = S_EMIT;
            end
            S_RET_RD:
            begin
                // table read of the running slot is in flight
                state_next = S_RET_APPLY;
            end
            S_RET_APPLY:
            begin
                cmd.ret_apply = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.none_left)
                begin
                    cmd.res_empty = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.res_grant = 1'b1;
                    state_next    = S_EMIT;
                end
                else if (stat.scan_end)
                begin
                    cmd.res_empty = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[hdl/lts_datapath.sv]
// Ticket table, totals, serial modulo unit, slot scan and output register.
`default_nettype none

module lts_datapath #(
    parameter int MAX_TASKS   = lts_pkg::MAX_TASKS_DEF,
    parameter int TICKET_BITS = lts_pkg::TICKET_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lts_pkg::req_word_t req_word,
    input  wire lts_pkg::cmd_t     cmd,
    output lts_pkg::stat_t         stat,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output lts_pkg::rsp_word_t     rsp_word
);

    localparam int IDX_W   = $clog2(MAX_TASKS);
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int TOTAL_W = TICKET_BITS + IDX_W;
    localparam int SUM_W   = TOTAL_W + 1;
    localparam int DCNT_W  = $clog2(lts_pkg::RND_BITS);

    // ticket store, undefined until written
    logic [TICKET_BITS-1:0] ticket_mem [MAX_TASKS];
    logic [TICKET_BITS-1:0] rd_data_reg;

    logic [MAX_TASKS-1:0]   live_reg, live_next;
    logic [CNT_W-1:0]       live_cnt_reg, live_cnt_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]       free_reg, free_next;
    logic [IDX_W-1:0]       run_slot_reg, run_slot_next;
    logic                   run_valid_reg, run_valid_next;

    logic [TICKET_BITS-1:0] ticket_reg;
    logic                   done_reg;
    logic [lts_pkg::RND_BITS-1:0] rnd_reg, rnd_next;

    logic [TOTAL_W-1:0]     rem_reg, rem_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;

    logic [CNT_W-1:0]       issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]       acc_idx_reg, acc_idx_next;
    logic                   acc_valid_reg, acc_valid_next;
    logic [TOTAL_W-1:0]     sum_reg, sum_next;

    logic [1:0]             res_status_reg, res_status_next;
    logic [3:0]             res_slot_reg, res_slot_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    lts_pkg::rsp_word_t     rsp_word_reg, rsp_word_next;

    logic [31:0]            tk_wide;
    logic [TICKET_BITS-1:0] ticket_in;
    logic                   table_full;
    logic                   ret_any, ret_hit;
    logic [TOTAL_W-1:0]     rd_ext;
    logic [SUM_W-1:0]       shifted, total_ext;
    logic                   scan_issue;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [SUM_W-1:0]       sum_add;
    logic                   acc_live;
    logic [7:0]             free_slot8, acc_slot8;

    assign tk_wide   = 32'(req_word.ticket_count);
    assign ticket_in = tk_wide[TICKET_BITS-1:0];

    assign table_full = (free_reg == CNT_W'(MAX_TASKS));
    assign ret_any    = done_reg && run_valid_reg;
    assign ret_hit    = ret_any && live_reg[run_slot_reg];
    assign rd_ext     = TOTAL_W'(rd_data_reg);

    assign shifted    = {rem_reg, rnd_reg[lts_pkg::RND_BITS-1]};
    assign total_ext  = SUM_W'(total_reg);

    assign scan_issue = cmd.scan_step && (issue_idx_reg < CNT_W'(MAX_TASKS));
    assign rd_addr    = scan_issue ? issue_idx_reg[IDX_W-1:0] : run_slot_reg;
    assign wr_en      = cmd.do_load && !table_full;

    assign acc_live   = acc_valid_reg && live_reg[acc_idx_reg];
    assign sum_add    = SUM_W'(sum_reg) + SUM_W'(rd_data_reg);

    assign free_slot8 = 8'(free_reg[IDX_W-1:0]);
    assign acc_slot8  = 8'(acc_idx_reg);

    assign stat.in_kind   = req_word.kind;
    assign stat.none_left = (live_cnt_reg == '0) || (total_reg == '0);
    assign stat.div_last  = (dcnt_reg == '0);
    // winner is rem + 1, so the running sum reaches it once it exceeds rem
    assign stat.scan_hit  = acc_live && (sum_add > SUM_W'(rem_reg));
    assign stat.scan_end  = !acc_valid_reg && (issue_idx_reg == CNT_W'(MAX_TASKS));
    assign stat.out_busy  = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ticket_mem[free_reg[IDX_W-1:0]] <= ticket_reg;
        rd_data_reg <= ticket_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ticket_reg <= ticket_in;
            done_reg   <= req_word.current_done;
        end
        rnd_reg        <= rnd_next;
        rem_reg        <= rem_next;
        sum_reg        <= sum_next;
        acc_idx_reg    <= acc_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_word_reg   <= rsp_word_next;
    end

    always_comb
    begin
        live_next       = live_reg;
        live_cnt_next   = live_cnt_reg;
        total_next      = total_reg;
        free_next       = free_reg;
        run_slot_next   = run_slot_reg;
        run_valid_next  = run_valid_reg;
        rnd_next        = rnd_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        issue_idx_next  = issue_idx_reg;
        acc_idx_next    = acc_idx_reg;
        acc_valid_next  = acc_valid_reg;
        sum_next        = sum_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_word_next   = rsp_word_reg;

        if (cmd.capture)
            rnd_next = req_word.random_value;

        if (cmd.do_load)
        begin
            if (table_full)
            begin
                res_status_next = lts_pkg::ST_FULL;
                res_slot_next   = '0;
            end
            else
            begin
                live_next[free_reg[IDX_W-1:0]] = 1'b1;
                live_cnt_next   = live_cnt_reg + 1'b1;
                total_next      = total_reg + TOTAL_W'(ticket_reg);
                free_next       = free_reg + 1'b1;
                res_status_next = lts_pkg::ST_LOADED;
                res_slot_next   = free_slot8[3:0];
            end
        end

        if (cmd.ret_apply)
        begin
            if (ret_hit)
            begin
                total_next = (total_reg >= rd_ext) ? total_reg - rd_ext : '0;
                live_next[run_slot_reg] = 1'b0;
                live_cnt_next = live_cnt_reg - 1'b1;
            end
            if (ret_any)
                run_valid_next = 1'b0;
        end

        if (cmd.div_start)
        begin
            rem_next  = '0;
            dcnt_next = DCNT_W'(lts_pkg::RND_BITS - 1);
        end

        // restoring remainder, one bit of the draw per step
        if (cmd.div_step)
        begin
            if (shifted >= total_ext)
                rem_next = TOTAL_W'(shifted - total_ext);
            else
                rem_next = TOTAL_W'(shifted);
            rnd_next  = {rnd_reg[lts_pkg::RND_BITS-2:0], 1'b0};
            dcnt_next = dcnt_reg - 1'b1;
        end

        if (cmd.scan_start)
        begin
            issue_idx_next = '0;
            acc_valid_next = 1'b0;
            sum_next       = '0;
        end

        if (cmd.scan_step)
        begin
            if (scan_issue)
            begin
                acc_idx_next   = issue_idx_reg[IDX_W-1:0];
                acc_valid_next = 1'b1;
                issue_idx_next = issue_idx_reg + 1'b1;
            end
            else
                acc_valid_next = 1'b0;
            if (acc_live)
                sum_next = TOTAL_W'(sum_add);
        end

        if (cmd.res_grant)
        begin
            run_slot_next   = acc_idx_reg;
            run_valid_next  = 1'b1;
            res_status_next = lts_pkg::ST_GRANTED;
            res_slot_next   = acc_slot8[3:0];
        end

        if (cmd.res_empty)
        begin
            run_valid_next  = 1'b0;
            res_status_next = lts_pkg::ST_EMPTY;
            res_slot_next   = '0;
        end

        if (cmd.push)
        begin
            rsp_valid_next       = 1'b1;
            rsp_word_next.status = res_status_reg;
            rsp_word_next.slot   = res_slot_reg;
        end
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= '0;
            live_cnt_reg  <= '0;
            total_reg     <= '0;
            free_reg      <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            issue_idx_reg <= '0;
            acc_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg      <= live_next;
            live_cnt_reg  <= live_cnt_next;
            total_reg     <= total_next;
            free_reg      <= free_next;
            run_slot_reg  <= run_slot_next;
            run_valid_reg <= run_valid_next;
            dcnt_reg      <= dcnt_next;
            issue_idx_reg <= issue_idx_next;
            acc_valid_reg <= acc_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

[hdl/lottery_task_selector_top.sv]
// Top level of the lottery task selector: sequencer plus datapath.
//
// Lottery scheduler. A load word appends a task and its tickets to the next
// free slot (slots are never reused; a full table answers status 3). A
// schedule word optionally retires the running task, then draws the winner
// as random_value mod total + 1 and grants the first live slot whose running
// ticket sum reaches it. One response word per request word. A load passes
// through the load and emit states. A schedule reads and retires the running
// slot and checks for tickets left, runs the bit-serial remainder unit (one
// bit of the draw per cycle), reads the table in slot order pipelined through
// the table's registered read port, then passes the result through the emit
// state into the output register. With no tickets left the check answers
// empty directly. A new request is taken once the previous one has reached
// the output register, even if that response is still stalled.
`default_nettype none

module lottery_task_selector_top #(
    parameter int MAX_TASKS   = lts_pkg::MAX_TASKS_DEF,
    parameter int TICKET_BITS = lts_pkg::TICKET_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire lts_pkg::req_word_t req_word,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output lts_pkg::rsp_word_t      rsp_word
);

    lts_pkg::cmd_t  cmd;
    lts_pkg::stat_t stat;

    lts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lts_datapath #(
        .MAX_TASKS   (MAX_TASKS),
        .TICKET_BITS (TICKET_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

`default_nettype wire

[bench/tb_lottery_task_selector_top.sv]
// Testbench for the lottery task selector: queue-fed driver, checking monitor, predictor.
`timescale 1ns / 1ps

module tb_lottery_task_selector_top;

    localparam int SLOTS       = lts_pkg::MAX_TASKS_DEF;
    localparam int RANDOM_REQS = 430;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 80;

    typedef struct {
        lts_pkg::req_word_t word;
        bit                 drain;
    } pending_req_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    lts_pkg::req_word_t req_word = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    lts_pkg::rsp_word_t rsp_word;

    pending_req_t       request_backlog[$];
    lts_pkg::rsp_word_t pending_outcomes[$];

    // Predictor state
    logic [15:0] task_tickets[SLOTS];
    bit          task_live[SLOTS];
    logic [19:0] ticket_sum;
    int          free_slot;
    logic [3:0]  run_slot;
    bit          run_valid;

    int gap_left = 0;
    int stall_left = 0;
    bit calm_sender = 1'b0;
    bit calm_receiver = 1'b0;
    int received = 0;
    int fail_count = 0;
    int cycles = 0;

    lottery_task_selector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always #6 clk = ~clk;

    // Apply one request word to the predictor and return the word the block should answer.
    task automatic lottery_outcome(input lts_pkg::req_word_t w,
                                   output lts_pkg::rsp_word_t r);
        logic [31:0] rem;
        logic [23:0] winner;
        logic [23:0] acc;
        bit          any;
        bit          hit;
        int          i;
        r = '0;
        if (w.kind == lts_pkg::KIND_LOAD) begin
            if (free_slot >= SLOTS) begin
                r.status = lts_pkg::ST_FULL;
            end
            else begin
                task_tickets[free_slot] = w.ticket_count;
                task_live[free_slot] = 1'b1;
                ticket_sum = ticket_sum + w.ticket_count;
                r.status = lts_pkg::ST_LOADED;
                r.slot = free_slot[3:0];
                free_slot++;
            end
        end
        else begin
            if (w.current_done && run_valid) begin
                if (task_live[run_slot]) begin
                    ticket_sum = (ticket_sum >= task_tickets[run_slot]) ?
                                 ticket_sum - task_tickets[run_slot] : '0;
                    task_live[run_slot] = 1'b0;
                end
                run_valid = 1'b0;
            end
            any = 1'b0;
            for (i = 0; i < SLOTS; i++)
                if (task_live[i])
                    any = 1'b1;
            hit = 1'b0;
            if (any && ticket_sum != 0) begin
                rem = w.random_value % {12'd0, ticket_sum};
                winner = rem[23:0] + 24'd1;
                acc = '0;
                for (i = 0; i < SLOTS; i++) begin
                    if (task_live[i] && !hit) begin
                        acc = acc + task_tickets[i];
                        if (acc >= winner) begin
                            hit = 1'b1;
                            run_slot = i[3:0];
                            run_valid = 1'b1;
                            r.status = lts_pkg::ST_GRANTED;
                            r.slot = i[3:0];
                        end
                    end
                end
            end
            if (!hit) begin
                run_valid = 1'b0;
                r.status = lts_pkg::ST_EMPTY;
                r.slot = '0;
            end
        end
    endtask

    task automatic queue_load(input logic [15:0] tickets);
        pending_req_t p;
        p.word = '0;
        p.word.kind = lts_pkg::KIND_LOAD;
        p.word.ticket_count = tickets;
        p.word.random_value = $urandom;
        p.word.current_done = 1'($urandom_range(0, 1));
        p.drain = 1'b0;
        request_backlog.push_back(p);
    endtask

    task automatic queue_sched(input logic [31:0] rnd, input bit done, input bit drain);
        pending_req_t p;
        p.word = '0;
        p.word.kind = lts_pkg::KIND_SCHED;
        p.word.ticket_count = 16'($urandom);
        p.word.random_value = rnd;
        p.word.current_done = done;
        p.drain = drain;
        request_backlog.push_back(p);
    endtask

    // Driver: offer words from the backlog, with a random gap after each accepted word.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req_word <= '0;
            gap_left <= 0;
        end
        else begin : drive
            bit                 offering;
            int                 gap;
            lts_pkg::rsp_word_t outcome;
            offering = req_valid;
            gap = gap_left;
            if (req_valid && !req_stall) begin
                lottery_outcome(req_word, outcome);
                pending_outcomes.push_back(outcome);
                void'(request_backlog.pop_front());
                offering = 1'b0;
                gap = calm_sender ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 19) == 0)
                    calm_sender = ~calm_sender;
            end
            if (!offering) begin
                if (gap > 0)
                    gap--;
                else if (request_backlog.size() > 0 &&
                         (!request_backlog[0].drain || pending_outcomes.size() == 0)) begin
                    offering = 1'b1;
                    req_word <= request_backlog[0].word;
                end
            end
            req_valid <= offering;
            gap_left <= gap;
        end
    end

    // Monitor: take response words, check them in order, stall at random.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else begin : watch
            int                 hold;
            lts_pkg::rsp_word_t want;
            hold = stall_left;
            if (rsp_valid && !rsp_stall) begin
                received++;
                if (pending_outcomes.size() == 0) begin
                    $error("response word with none expected: status %0d slot %0d",
                           rsp_word.status, rsp_word.slot);
                    fail_count++;
                end
                else begin
                    want = pending_outcomes.pop_front();
                    if (rsp_word.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, rsp_word.status);
                        fail_count++;
                    end
                    if (rsp_word.slot !== want.slot) begin
                        $error("slot expected %0d actual %0d", want.slot, rsp_word.slot);
                        fail_count++;
                    end
                end
                hold = calm_receiver ? 0 : $urandom_range(0, 19);
                // hold off long enough that the block backs up into its input
                if (received == 150)
                    hold = LONG_HOLD;
                if ($urandom_range(0, 19) == 0)
                    calm_receiver = ~calm_receiver;
            end
            else if (hold > 0) begin
                hold--;
            end
            stall_left <= hold;
            rsp_stall <= (hold > 0);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int          n;
        int          pick;
        logic [31:0] rnd;
        for (n = 0; n < SLOTS; n++) begin
            task_tickets[n] = '0;
            task_live[n] = 1'b0;
        end
        ticket_sum = '0;
        free_slot = 0;
        run_slot = '0;
        run_valid = 1'b0;

        // Directed: empty table, zero-ticket task, ticket extremes, retire paths.
        queue_sched(32'd0, 1'b1, 1'b0);
        queue_load(16'd0);
        queue_sched($urandom, 1'b0, 1'b0);
        queue_load(16'hFFFF);
        queue_load(16'd1);
        queue_sched(32'd0, 1'b0, 1'b0);
        queue_sched(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_sched(32'd65534, 1'b0, 1'b0);
        queue_sched($urandom, 1'b1, 1'b0);
        queue_sched($urandom, 1'b1, 1'b0);
        queue_sched($urandom, 1'b1, 1'b0);
        queue_load(16'h8000);
        queue_load(16'h5555);
        queue_load(16'hAAAA);
        queue_sched(32'hAAAA_AAAA, 1'b0, 1'b0);
        queue_sched(32'h5555_5555, 1'b0, 1'b0);
        queue_sched(32'h8000_0000, 1'b1, 1'b0);

        // Random: mostly schedules, sparse loads that fill the table and then meet it full, rare retires.
        for (n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 9) begin
                if ($urandom_range(0, 1) == 0)
                    queue_load(16'($urandom_range(1, 15)));
                else
                    queue_load(16'($urandom_range(1, 65535)));
            end
            else begin
                rnd = $urandom;
                if (pick < 12)
                    rnd = (pick == 10) ? 32'd0 : 32'hFFFF_FFFF;
                queue_sched(rnd, $urandom_range(0, 39) == 0, n == 100 || n == 300);
            end
        end

        @(posedge rst_n);
        while (request_backlog.size() != 0 || pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

endmodule
